### design/cif_pkg.sv
`timescale 1ns / 1ps
// cif_pkg: payload types, field widths and shared helpers for the contact impulse block
// no dependencies; used by the interfaces, the divider and the top level

package cif_pkg;

	localparam int VEL_W    = 32;
	localparam int IM_W     = 31;
	localparam int MAT_W    = 48;
	localparam int COEF_W   = 16;
	localparam int DIR_W    = 16;
	localparam int DIR_BITS = 14;
	localparam int IMP_W    = 31;
	localparam int MU_W     = COEF_W + 1;
	// Q4.12 unit, and the shift that also halves the sum of two coefficients
	localparam int COEF_ONE = 4096;
	localparam int MU_SHIFT = 13;
	// one register to set up, one per quotient bit
	localparam int DIV_LAT  = IMP_W + 1;
	// velocity kick: widened step and sum before saturation
	localparam int KDV_W    = 64;
	localparam int KSUM_W   = KDV_W + 2;

	localparam logic [IMP_W-1:0] IMP_MAX = '1;
	localparam logic signed [VEL_W-1:0] VEL_MAX = 32'sh7FFFFFFF;
	localparam logic signed [VEL_W-1:0] VEL_MIN = 32'sh80000000;

	typedef struct packed {
		logic signed [VEL_W-1:0] vel_a_x;
		logic signed [VEL_W-1:0] vel_a_y;
		logic signed [VEL_W-1:0] vel_b_x;
		logic signed [VEL_W-1:0] vel_b_y;
		logic [IM_W-1:0]         inv_mass_a;
		logic [IM_W-1:0]         inv_mass_b;
		logic [MAT_W-1:0]        material_a;
		logic [MAT_W-1:0]        material_b;
		logic signed [DIR_W-1:0] normal_x;
		logic signed [DIR_W-1:0] normal_y;
	} cif_in_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] new_vel_a_x;
		logic signed [VEL_W-1:0] new_vel_a_y;
		logic signed [VEL_W-1:0] new_vel_b_x;
		logic signed [VEL_W-1:0] new_vel_b_y;
		logic [IMP_W-1:0]        normal_impulse;
		logic                    separating;
	} cif_out_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] ax;
		logic signed [VEL_W-1:0] ay;
		logic signed [VEL_W-1:0] bx;
		logic signed [VEL_W-1:0] by;
	} vel4_t;

	// magnitude of a Q1.14 direction component, full negative value included
	function automatic logic [DIR_W-1:0] dir_mag(input logic signed [DIR_W-1:0] d);
		return d[DIR_W-1] ? DIR_W'(-d) : DIR_W'(d);
	endfunction

	// v plus or minus a magnitude, saturated to the velocity range
	function automatic logic signed [VEL_W-1:0] kick_add(
		input logic signed [VEL_W-1:0] v,
		input logic [KDV_W-1:0]        dv,
		input logic                    neg
	);
		logic signed [KSUM_W-1:0] step;
		logic signed [KSUM_W-1:0] sum;
		step = $signed({2'b00, dv});
		if (neg) begin
			step = -step;
		end
		sum = KSUM_W'(v) + step;
		if (sum > KSUM_W'(VEL_MAX)) begin
			return VEL_MAX;
		end else if (sum < KSUM_W'(VEL_MIN)) begin
			return VEL_MIN;
		end
		return sum[VEL_W-1:0];
	endfunction

endpackage

### design/cif_if.sv
`timescale 1ns / 1ps
// cif_in_if, cif_out_if: valid/ready channels carrying one contact and one result beat
// depends on cif_pkg for the payload types

interface cif_in_if;
	logic              valid;
	logic              ready;
	cif_pkg::cif_in_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface cif_out_if;
	logic              valid;
	logic              ready;
	cif_pkg::cif_out_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### design/contact_impulse_with_friction_core.sv
`timescale 1ns / 1ps
// contact_impulse_with_friction_core: 2D contact resolution, restitution and Coulomb friction
// depends on cif_pkg, cif_if and cif_div
//
//  channel  | dir | handshake    | beat
//  ---------+-----+--------------+--------------------------------------------
//  contact  | in  | valid/ready  | cif_in_t: velocities, inverse masses, materials, normal
//  result   | out | valid/ready  | cif_out_t: new velocities, normal impulse, separating
//
// one contact per cycle unless the pipeline is frozen; each passes through the two 32-stage
// dividers (normal impulse, then tangential impulse) and the kick stages around them.
// reset clears the stage valid bits and the output flags only.
// the output register has a spare slot behind it; the pipeline freezes only while
// that slot holds a beat, so nothing is lost or repeated under back-pressure.

module contact_impulse_with_friction_core #(
	parameter int VEL_FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	cif_in_if.sink    contact,
	cif_out_if.source result
);
	import cif_pkg::*;

	localparam int RV_W   = VEL_W + 1;
	localparam int PRJ_W  = RV_W + DIR_W;
	localparam int N1A_W  = PRJ_W - DIR_BITS;
	localparam int NUM1_W = N1A_W + MU_W;
	localparam int DEN1_W = IM_W + 1 + 12;
	localparam int P_W    = DIR_W + 1;
	localparam int W_W    = RV_W + P_W;
	localparam int NUM2_W = W_W - DIR_BITS;
	localparam int CMP_W  = IMP_W + DIR_W;
	localparam int CM_W   = CMP_W - DIR_BITS;
	localparam int JM_W   = IMP_W + MU_W;
	localparam int NSTG   = 4 + DIV_LAT + 6 + DIV_LAT + 4;

	typedef struct packed {
		vel4_t                   vel;
		logic [IM_W-1:0]         ia;
		logic [IM_W-1:0]         ib;
		logic signed [DIR_W-1:0] nx;
		logic signed [DIR_W-1:0] ny;
		logic [IM_W:0]           s;
		logic [MU_W-1:0]         mus;
		logic [MU_W-1:0]         mud;
	} ctx_t;

	typedef struct packed {
		ctx_t ctx;
		logic sep;
		logic z;
	} side1_t;

	typedef struct packed {
		ctx_t             ctx;
		logic [IMP_W-1:0] j;
		logic             sep;
		logic             z;
		logic             wneg;
		logic             wnz;
	} side2_t;

	// handshake and pipeline enable
	logic     en;
	logic     in_fire;
	logic     push;
	logic [NSTG-1:0] vld_q;
	logic     out_v_q;
	logic     spare_v_q;
	cif_out_t out_q;
	cif_out_t spare_q;
	cif_out_t res_c;

	assign en            = ~spare_v_q;
	assign contact.ready = en;
	assign in_fire       = contact.valid & en;
	assign push          = en & vld_q[NSTG-1];

	// stage registers
	ctx_t                    ctx_s1, ctx_s2, ctx_s3, ctx_s4;
	logic [COEF_W-1:0]       e_s1, e_s2, e_s3;
	logic signed [RV_W-1:0]  rvx_s1, rvy_s1;
	logic signed [PRJ_W-1:0] prx_s2, pry_s2;
	logic                    sep_s3, z_s3;
	logic                    sep_s3_d, z_s3_d;
	logic [N1A_W-1:0]        a_s3;
	logic [NUM1_W-1:0]       num1_s4;
	side1_t                  side1_q [0:DIV_LAT-1];
	logic [IMP_W-1:0]        quo1;

	side1_t                  sd_s5, sd_s6;
	logic [IMP_W-1:0]        j_s5, j_s6, j_s7, j_s8, j_s9, j_s10;
	logic [CM_W-1:0]         cmx_s5, cmy_s5;
	logic [KDV_W-1:0]        pax_s6, pay_s6, pbx_s6, pby_s6;
	ctx_t                    ctx_s7, ctx_s8, ctx_s9, ctx_s10;
	logic                    sep_s7, sep_s8, sep_s9, sep_s10;
	logic                    z_s7, z_s8, z_s9, z_s10;
	logic signed [RV_W-1:0]  rv1x_s8, rv1y_s8;
	logic signed [W_W-1:0]   wpx_s9, wpy_s9;
	logic [NUM2_W-1:0]       num2_s10;
	logic                    wneg_s10, wnz_s10;
	side2_t                  side2_q [0:DIV_LAT-1];
	logic [IMP_W-1:0]        quo2;

	side2_t                  sd_s11;
	logic [IMP_W-1:0]        jt_s11;
	logic [JM_W-1:0]         jm_s11, jd_s11;
	ctx_t                    ctx_s12, ctx_s13, ctx_s14;
	logic [IMP_W-1:0]        j_s12, j_s13, j_s14;
	logic                    sep_s12, sep_s13, sep_s14;
	logic [IMP_W-1:0]        m_s12;
	logic                    fxneg_s12, fyneg_s12, fxneg_s13, fyneg_s13, fxneg_s14, fyneg_s14;
	logic [CM_W-1:0]         cfx_s13, cfy_s13;
	logic [KDV_W-1:0]        fax_s14, fay_s14, fbx_s14, fby_s14;

	// combinational terms between stages
	cif_in_t                 d;
	ctx_t                    ctx_in;
	logic [COEF_W-1:0]       ea, eb;
	logic signed [PRJ_W-1:0] vn_c;
	logic [PRJ_W-1:0]        vnmag_c;
	logic [MU_W-1:0]         e1_c;
	side1_t                  sd1;
	logic [IMP_W-1:0]        j5_c;
	logic [CMP_W-1:0]        cmx5_c, cmy5_c;
	vel4_t                   vel7_c;
	ctx_t                    ctx7_c;
	logic signed [P_W-1:0]   px_c, py_c;
	logic signed [W_W-1:0]   w_c;
	logic [W_W-1:0]          wmag_c;
	side2_t                  sd2;
	logic                    stat_c, apply_c;
	logic [JM_W-1:0]         dynf_c;
	logic [IMP_W-1:0]        dyn_c, m12_c;
	logic [CMP_W-1:0]        cfx13_c, cfy13_c;

	assign d   = contact.data;
	assign sd1 = side1_q[DIV_LAT-1];
	assign sd2 = side2_q[DIV_LAT-1];

	// input stage: relative velocity, mass sum, material coefficients
	always_comb begin
		ea             = d.material_a[47:32];
		eb             = d.material_b[47:32];
		ctx_in.vel.ax  = d.vel_a_x;
		ctx_in.vel.ay  = d.vel_a_y;
		ctx_in.vel.bx  = d.vel_b_x;
		ctx_in.vel.by  = d.vel_b_y;
		ctx_in.ia      = d.inv_mass_a;
		ctx_in.ib      = d.inv_mass_b;
		ctx_in.nx      = d.normal_x;
		ctx_in.ny      = d.normal_y;
		ctx_in.s       = {1'b0, d.inv_mass_a} + {1'b0, d.inv_mass_b};
		ctx_in.mus     = MU_W'(d.material_a[31:16]) + MU_W'(d.material_b[31:16]);
		ctx_in.mud     = MU_W'(d.material_a[15:0]) + MU_W'(d.material_b[15:0]);
	end

	// normal projection and restitution numerator
	always_comb begin
		vn_c    = prx_s2 + pry_s2;
		vnmag_c = vn_c[PRJ_W-1] ? PRJ_W'(-vn_c) : PRJ_W'(vn_c);
		e1_c    = MU_W'(e_s3) + MU_W'(COEF_ONE);
	end

	// normal impulse, then its component along each axis
	always_comb begin
		j5_c   = (sd1.sep | sd1.z) ? '0 : quo1;
		cmx5_c = CMP_W'(j5_c) * CMP_W'(dir_mag(sd1.ctx.nx));
		cmy5_c = CMP_W'(j5_c) * CMP_W'(dir_mag(sd1.ctx.ny));
	end

	// normal kick: A against the normal, B along it
	always_comb begin
		vel7_c.ax = kick_add(sd_s6.ctx.vel.ax, pax_s6 >> VEL_FRAC_BITS, ~sd_s6.ctx.nx[DIR_W-1]);
		vel7_c.ay = kick_add(sd_s6.ctx.vel.ay, pay_s6 >> VEL_FRAC_BITS, ~sd_s6.ctx.ny[DIR_W-1]);
		vel7_c.bx = kick_add(sd_s6.ctx.vel.bx, pbx_s6 >> VEL_FRAC_BITS, sd_s6.ctx.nx[DIR_W-1]);
		vel7_c.by = kick_add(sd_s6.ctx.vel.by, pby_s6 >> VEL_FRAC_BITS, sd_s6.ctx.ny[DIR_W-1]);
		ctx7_c     = sd_s6.ctx;
		ctx7_c.vel = vel7_c;
	end

	// tangential projection on p = (-ny, nx)
	always_comb begin
		px_c   = -(P_W'(ctx_s8.ny));
		py_c   = P_W'(ctx_s8.nx);
		w_c    = wpx_s9 + wpy_s9;
		wmag_c = w_c[W_W-1] ? W_W'(-w_c) : W_W'(w_c);
	end

	// static or dynamic friction magnitude
	always_comb begin
		stat_c  = JM_W'({jt_s11, MU_SHIFT'(0)}) < jm_s11;
		dynf_c  = jd_s11 >> MU_SHIFT;
		dyn_c   = (dynf_c > JM_W'(IMP_MAX)) ? IMP_MAX : dynf_c[IMP_W-1:0];
		apply_c = ~sd_s11.sep & ~sd_s11.z & sd_s11.wnz;
		m12_c   = apply_c ? (stat_c ? jt_s11 : dyn_c) : '0;
	end

	// friction components along the signed tangent
	always_comb begin
		cfx13_c = CMP_W'(m_s12) * CMP_W'(dir_mag(ctx_s12.ny));
		cfy13_c = CMP_W'(m_s12) * CMP_W'(dir_mag(ctx_s12.nx));
	end

	// friction kick: A along the tangent, B against it
	always_comb begin
		res_c.new_vel_a_x    = kick_add(ctx_s14.vel.ax, fax_s14 >> VEL_FRAC_BITS, fxneg_s14);
		res_c.new_vel_a_y    = kick_add(ctx_s14.vel.ay, fay_s14 >> VEL_FRAC_BITS, fyneg_s14);
		res_c.new_vel_b_x    = kick_add(ctx_s14.vel.bx, fbx_s14 >> VEL_FRAC_BITS, ~fxneg_s14);
		res_c.new_vel_b_y    = kick_add(ctx_s14.vel.by, fby_s14 >> VEL_FRAC_BITS, ~fyneg_s14);
		res_c.normal_impulse = j_s14;
		res_c.separating     = sep_s14;
	end

	// dividers: normal impulse and tangential impulse
	cif_div #(
		.NUM_W (NUM1_W),
		.DEN_W (DEN1_W),
		.SH    (VEL_FRAC_BITS)
	) u_div_norm (
		.clk (clk),
		.en  (en),
		.num (num1_s4),
		.den ({ctx_s4.s, 12'b0}),
		.quo (quo1)
	);

	cif_div #(
		.NUM_W (NUM2_W),
		.DEN_W (IM_W + 1),
		.SH    (VEL_FRAC_BITS)
	) u_div_tan (
		.clk (clk),
		.en  (en),
		.num (num2_s10),
		.den (ctx_s10.s),
		.quo (quo2)
	);

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTG-2:0], in_fire};
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1  <= ctx_in;
			e_s1    <= (ea < eb) ? ea : eb;
			rvx_s1  <= RV_W'(d.vel_b_x) - RV_W'(d.vel_a_x);
			rvy_s1  <= RV_W'(d.vel_b_y) - RV_W'(d.vel_a_y);

			ctx_s2  <= ctx_s1;
			e_s2    <= e_s1;
			prx_s2  <= PRJ_W'(rvx_s1) * PRJ_W'(ctx_s1.nx);
			pry_s2  <= PRJ_W'(rvy_s1) * PRJ_W'(ctx_s1.ny);

			ctx_s3  <= ctx_s2;
			e_s3    <= e_s2;
			sep_s3  <= vn_c > 0;
			z_s3    <= ctx_s2.s == '0;
			a_s3    <= vnmag_c[PRJ_W-1:DIR_BITS];

			ctx_s4  <= ctx_s3;
			num1_s4 <= NUM1_W'(a_s3) * NUM1_W'(e1_c);

			side1_q[0] <= '{ctx: ctx_s4, sep: sep_s3_d, z: z_s3_d};
			for (int k = 1; k < DIV_LAT; k++) begin
				side1_q[k] <= side1_q[k-1];
			end

			sd_s5   <= sd1;
			j_s5    <= j5_c;
			cmx_s5  <= cmx5_c[CMP_W-1:DIR_BITS];
			cmy_s5  <= cmy5_c[CMP_W-1:DIR_BITS];

			sd_s6   <= sd_s5;
			j_s6    <= j_s5;
			pax_s6  <= KDV_W'(sd_s5.ctx.ia) * KDV_W'(cmx_s5);
			pay_s6  <= KDV_W'(sd_s5.ctx.ia) * KDV_W'(cmy_s5);
			pbx_s6  <= KDV_W'(sd_s5.ctx.ib) * KDV_W'(cmx_s5);
			pby_s6  <= KDV_W'(sd_s5.ctx.ib) * KDV_W'(cmy_s5);

			ctx_s7      <= ctx7_c;
			j_s7        <= j_s6;
			sep_s7      <= sd_s6.sep;
			z_s7        <= sd_s6.z;

			ctx_s8  <= ctx_s7;
			j_s8    <= j_s7;
			sep_s8  <= sep_s7;
			z_s8    <= z_s7;
			rv1x_s8 <= RV_W'(ctx_s7.vel.bx) - RV_W'(ctx_s7.vel.ax);
			rv1y_s8 <= RV_W'(ctx_s7.vel.by) - RV_W'(ctx_s7.vel.ay);

			ctx_s9  <= ctx_s8;
			j_s9    <= j_s8;
			sep_s9  <= sep_s8;
			z_s9    <= z_s8;
			wpx_s9  <= W_W'(rv1x_s8) * W_W'(px_c);
			wpy_s9  <= W_W'(rv1y_s8) * W_W'(py_c);

			ctx_s10  <= ctx_s9;
			j_s10    <= j_s9;
			sep_s10  <= sep_s9;
			z_s10    <= z_s9;
			num2_s10 <= wmag_c[W_W-1:DIR_BITS];
			wneg_s10 <= w_c[W_W-1];
			wnz_s10  <= w_c != '0;

			side2_q[0] <= '{ctx: ctx_s10, j: j_s10, sep: sep_s10, z: z_s10,
				wneg: wneg_s10, wnz: wnz_s10};
			for (int k = 1; k < DIV_LAT; k++) begin
				side2_q[k] <= side2_q[k-1];
			end

			sd_s11  <= sd2;
			jt_s11  <= quo2;
			jm_s11  <= JM_W'(sd2.j) * JM_W'(sd2.ctx.mus);
			jd_s11  <= JM_W'(sd2.j) * JM_W'(sd2.ctx.mud);

			ctx_s12   <= sd_s11.ctx;
			j_s12     <= sd_s11.j;
			sep_s12   <= sd_s11.sep;
			m_s12     <= m12_c;
			fxneg_s12 <= sd_s11.wneg ? sd_s11.ctx.ny[DIR_W-1] : ~sd_s11.ctx.ny[DIR_W-1];
			fyneg_s12 <= sd_s11.wneg ? ~sd_s11.ctx.nx[DIR_W-1] : sd_s11.ctx.nx[DIR_W-1];

			ctx_s13   <= ctx_s12;
			j_s13     <= j_s12;
			sep_s13   <= sep_s12;
			fxneg_s13 <= fxneg_s12;
			fyneg_s13 <= fyneg_s12;
			cfx_s13   <= cfx13_c[CMP_W-1:DIR_BITS];
			cfy_s13   <= cfy13_c[CMP_W-1:DIR_BITS];

			ctx_s14   <= ctx_s13;
			j_s14     <= j_s13;
			sep_s14   <= sep_s13;
			fxneg_s14 <= fxneg_s13;
			fyneg_s14 <= fyneg_s13;
			fax_s14   <= KDV_W'(ctx_s13.ia) * KDV_W'(cfx_s13);
			fay_s14   <= KDV_W'(ctx_s13.ia) * KDV_W'(cfy_s13);
			fbx_s14   <= KDV_W'(ctx_s13.ib) * KDV_W'(cfx_s13);
			fby_s14   <= KDV_W'(ctx_s13.ib) * KDV_W'(cfy_s13);
		end
	end

	// separating and zero-mass flags kept level with the s4 numerator
	always_ff @(posedge clk) begin
		if (en) begin
			sep_s3_d <= sep_s3;
			z_s3_d   <= z_s3;
		end
	end

	// output register with one spare slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q   <= 1'b0;
			spare_v_q <= 1'b0;
		end else begin
			priority if (spare_v_q) begin
				if (result.ready) begin
					spare_v_q <= 1'b0;
				end
			end else if (push) begin
				if (!out_v_q || result.ready) begin
					out_v_q <= 1'b1;
				end else begin
					spare_v_q <= 1'b1;
				end
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end else begin
				// nothing moves
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (spare_v_q) begin
			if (result.ready) begin
				out_q <= spare_q;
			end
		end else if (push) begin
			if (!out_v_q || result.ready) begin
				out_q <= res_c;
			end else begin
				spare_q <= res_c;
			end
		end else begin
			// hold both slots
		end
	end

	assign result.valid = out_v_q;
	assign result.data  = out_q;

	// checks
	a_spare_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		spare_v_q |-> out_v_q)
		else $error("spare slot full while output register empty");

	a_stall_to_spare: assert property (@(posedge clk) disable iff (!arst_n)
		(push && out_v_q && !result.ready) |=> spare_v_q)
		else $error("beat from the pipeline not caught in the spare slot");

	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved while frozen");

	a_sep_no_impulse: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.data.separating) |-> (result.data.normal_impulse == '0))
		else $error("impulse reported on a separating contact");

endmodule

### design/cif_div.sv
`timescale 1ns / 1ps
// cif_div: pipelined restoring divider, quo = min(floor(num * 2^SH / den), 2^31 - 1)
// one quotient bit per stage; depends on cif_pkg

module cif_div #(
	parameter int NUM_W = 52,
	parameter int DEN_W = 44,
	parameter int SH    = 16
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [NUM_W-1:0]          num,
	input  logic [DEN_W-1:0]          den,
	output logic [cif_pkg::IMP_W-1:0] quo
);
	import cif_pkg::*;

	localparam int QW  = IMP_W;
	localparam int PSH = QW - SH;
	localparam int CW  = NUM_W + DEN_W + QW;

	logic [DEN_W-1:0] rem_s [0:QW];
	logic [QW-1:0]    quo_s [0:QW];
	logic [QW-1:0]    lo_s  [0:QW-1];
	logic [DEN_W-1:0] den_s [0:QW];
	logic             ovf_s [0:QW];

	logic [CW-1:0]       num_w;
	logic [CW-1:0]       lim_w;
	logic [NUM_W+QW-1:0] x_w;
	logic [NUM_W-1:0]    hi_w;

	// set-up: overflow test and the leading part of the shifted dividend
	always_comb begin
		num_w = CW'(num);
		lim_w = CW'(den) << PSH;
		x_w   = {num, QW'(0)} >> PSH;
		hi_w  = num >> PSH;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DEN_W'(hi_w);
			quo_s[0] <= '0;
			lo_s[0]  <= x_w[QW-1:0];
			den_s[0] <= den;
			ovf_s[0] <= num_w >= lim_w;
		end
	end

	// one compare and subtract per stage
	for (genvar i = 1; i <= QW; i++) begin : g_stage
		logic [DEN_W:0] trial;
		logic           ge;
		assign trial = {rem_s[i-1], lo_s[i-1][QW-1]};
		assign ge    = trial >= {1'b0, den_s[i-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? DEN_W'(trial - {1'b0, den_s[i-1]}) : trial[DEN_W-1:0];
				quo_s[i] <= {quo_s[i-1][QW-2:0], ge};
				den_s[i] <= den_s[i-1];
				ovf_s[i] <= ovf_s[i-1];
			end
		end

		if (i < QW) begin : g_lo
			always_ff @(posedge clk) begin
				if (en) begin
					lo_s[i] <= lo_s[i-1] << 1;
				end
			end
		end
	end

	assign quo = ovf_s[QW] ? IMP_MAX : quo_s[QW];

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for contact_impulse_with_friction_core
// depends on cif_pkg, cif_if and the core; checks every result against a built-in predictor

module testbench;
	import cif_pkg::*;

	localparam int FB = 16;
	localparam int LATENCY = 79;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cif_in_if  contact ();
	cif_out_if result ();

	contact_impulse_with_friction_core #(.VEL_FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n), .contact(contact), .result(result)
	);

	always #4 clk = ~clk;

	cif_in_t  pending_contacts[$];
	cif_out_t expected_results[$];
	int unsigned errors = 0;
	int unsigned n_sent = 0, n_got = 0, n_sep = 0, n_zero_mass = 0;
	bit stim_done = 1'b0;
	bit hold_long = 1'b0;

	// magnitude of a signed 64-bit value
	function automatic logic [63:0] mag(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
		if (v < -64'sh80000000) return -64'sh80000000;
		return v;
	endfunction

	// trunc(m * c / 2^sh) carrying the sign of c
	function automatic logic signed [63:0] scaled(input logic [63:0] m,
			input logic signed [63:0] c, input int sh);
		logic [63:0] p;
		p = (m * mag(c)) >> sh;
		return c[63] ? -$signed(p) : $signed(p);
	endfunction

	// floor(num * 2^sh / den) capped, long division one bit at a time
	function automatic logic [63:0] quot_capped(input logic [63:0] num,
			input logic [63:0] den, input int sh);
		logic [63:0] q, r;
		q = num / den;
		r = num % den;
		if (q > 64'h7FFFFFFF) return 64'h7FFFFFFF;
		for (int i = 0; i < sh; i++) begin
			q = q << 1;
			r = r << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 64'd1;
			end
			if (q > 64'h7FFFFFFF) return 64'h7FFFFFFF;
		end
		return q;
	endfunction

	// impulse m along direction (dx, dy) scaled by inverse mass, sign chosen by neg
	function automatic void apply_impulse(inout logic signed [63:0] vx,
			inout logic signed [63:0] vy,
			input logic [63:0] im, input logic [63:0] m,
			input logic signed [63:0] dx, input logic signed [63:0] dy, input bit neg);
		logic signed [63:0] cx, cy, dvx, dvy;
		cx = scaled(m, dx, DIR_BITS);
		cy = scaled(m, dy, DIR_BITS);
		dvx = scaled(im, cx, FB);
		dvy = scaled(im, cy, FB);
		vx = clamp32(neg ? vx - dvx : vx + dvx);
		vy = clamp32(neg ? vy - dvy : vy + dvy);
	endfunction

	function automatic cif_out_t resolve_contact(input cif_in_t c);
		cif_out_t r;
		logic signed [63:0] ax, ay, bx, by, nx, ny, px, py, vn, w;
		logic [63:0] ia, ib, msum, e, ea, eb, j, jt, mus, mud, m;
		ax = c.vel_a_x; ay = c.vel_a_y; bx = c.vel_b_x; by = c.vel_b_y;
		nx = c.normal_x; ny = c.normal_y;
		ia = c.inv_mass_a; ib = c.inv_mass_b;
		msum = ia + ib;
		j = 0;
		vn = (bx - ax) * nx + (by - ay) * ny;
		if (!(vn > 0) && msum != 0) begin
			ea = c.material_a[47:32];
			eb = c.material_b[47:32];
			e = (ea < eb) ? ea : eb;
			j = quot_capped((mag(vn) >> DIR_BITS) * (64'd4096 + e), msum << 12, FB);
			apply_impulse(ax, ay, ia, j, nx, ny, 1'b1);
			apply_impulse(bx, by, ib, j, nx, ny, 1'b0);
			px = -ny;
			py = nx;
			w = (bx - ax) * px + (by - ay) * py;
			if (w != 0) begin
				jt = quot_capped(mag(w) >> DIR_BITS, msum, FB);
				mus = 64'(c.material_a[31:16]) + 64'(c.material_b[31:16]);
				mud = 64'(c.material_a[15:0]) + 64'(c.material_b[15:0]);
				if ((jt << 13) < j * mus) begin
					m = jt;
				end else begin
					m = (j * mud) >> 13;
					if (m > 64'h7FFFFFFF) m = 64'h7FFFFFFF;
				end
				if (w < 0) begin
					px = -px;
					py = -py;
				end
				apply_impulse(ax, ay, ia, m, px, py, 1'b0);
				apply_impulse(bx, by, ib, m, px, py, 1'b1);
			end
		end
		r.new_vel_a_x = ax[31:0];
		r.new_vel_a_y = ay[31:0];
		r.new_vel_b_x = bx[31:0];
		r.new_vel_b_y = by[31:0];
		r.normal_impulse = j[30:0];
		r.separating = (vn > 0);
		return r;
	endfunction

	function automatic logic [31:0] rand_vel();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
			2: return 32'h7FFFFFFF - $urandom_range(0, 3);
			3: return 32'h80000000 + $urandom_range(0, 3);
			default: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
		endcase
	endfunction

	function automatic logic [30:0] rand_im();
		case ($urandom_range(0, 5))
			0: return 31'd0;
			1: return 31'($urandom());
			2: return 31'h7FFFFFFF;
			default: return 31'($urandom_range(1, 1 << 18));
		endcase
	endfunction

	function automatic logic [15:0] rand_coef();
		return ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 8192));
	endfunction

	function automatic cif_in_t rand_contact();
		cif_in_t c;
		int ang;
		real th;
		c.vel_a_x = rand_vel(); c.vel_a_y = rand_vel();
		c.vel_b_x = rand_vel(); c.vel_b_y = rand_vel();
		c.inv_mass_a = rand_im(); c.inv_mass_b = rand_im();
		c.material_a = {rand_coef(), rand_coef(), rand_coef()};
		c.material_b = {rand_coef(), rand_coef(), rand_coef()};
		// mostly unit normals, some axis-aligned, some raw bit patterns
		case ($urandom_range(0, 7))
			0: begin
				c.normal_x = 16'($urandom());
				c.normal_y = 16'($urandom());
			end
			1: begin
				c.normal_x = 16'sd0;
				c.normal_y = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
			end
			default: begin
				ang = $urandom_range(0, 3599);
				th = ang * 3.14159265358979 / 1800.0;
				c.normal_x = 16'($rtoi($cos(th) * 16384.0));
				c.normal_y = 16'($rtoi($sin(th) * 16384.0));
			end
		endcase
		return c;
	endfunction

	function automatic cif_in_t base_contact();
		cif_in_t c;
		c.vel_a_x = 32'sh00010000; c.vel_a_y = 32'sh00008000;
		c.vel_b_x = -32'sh00010000; c.vel_b_y = 32'sh00004000;
		c.inv_mass_a = 31'h10000; c.inv_mass_b = 31'h8000;
		c.material_a = {16'd2048, 16'd2048, 16'd1024};
		c.material_b = {16'd3072, 16'd1500, 16'd800};
		c.normal_x = 16'sd16384; c.normal_y = 16'sd0;
		return c;
	endfunction

	// stimulus: directed corners, then random contacts
	initial begin
		cif_in_t c;
		c = base_contact(); pending_contacts.push_back(c);
		// separating
		c = base_contact(); c.normal_x = -16'sd16384; pending_contacts.push_back(c);
		// both immovable
		c = base_contact(); c.inv_mass_a = 0; c.inv_mass_b = 0; pending_contacts.push_back(c);
		// one immovable
		c = base_contact(); c.inv_mass_b = 0; pending_contacts.push_back(c);
		// no tangential motion
		c = base_contact(); c.vel_a_y = 0; c.vel_b_y = 0; pending_contacts.push_back(c);
		// positive tangent side
		c = base_contact(); c.vel_b_y = 32'sh00100000; pending_contacts.push_back(c);
		// high friction: static case
		c = base_contact(); c.material_a[31:16] = 16'hFFFF; c.material_b[31:16] = 16'hFFFF;
		pending_contacts.push_back(c);
		// zero friction
		c = base_contact(); c.material_a = '0; c.material_b = '0; pending_contacts.push_back(c);
		// all ones materials
		c = base_contact(); c.material_a = '1; c.material_b = '1; pending_contacts.push_back(c);
		// extreme velocities and masses, saturation
		c = base_contact(); c.vel_a_x = 32'sh7FFFFFFF; c.vel_b_x = 32'sh80000000;
		c.vel_a_y = 32'sh80000000; c.vel_b_y = 32'sh7FFFFFFF;
		c.inv_mass_a = 31'h7FFFFFFF; c.inv_mass_b = 31'h7FFFFFFF; pending_contacts.push_back(c);
		c.inv_mass_a = 31'd1; c.inv_mass_b = 31'd0; pending_contacts.push_back(c);
		// diagonal and out-of-range normals
		c = base_contact(); c.normal_x = 16'sd11585; c.normal_y = -16'sd11585;
		pending_contacts.push_back(c);
		c = base_contact(); c.normal_x = 16'sh8000; c.normal_y = 16'sh7FFF;
		pending_contacts.push_back(c);
		c = base_contact(); c.normal_x = 16'sh7FFF; c.normal_y = 16'sh8000;
		pending_contacts.push_back(c);
		// resting contact, vn exactly zero
		c = base_contact(); c.vel_a_x = 0; c.vel_b_x = 0; pending_contacts.push_back(c);
		for (int i = 0; i < 800; i++) pending_contacts.push_back(rand_contact());
	end

	// reset
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver
	int unsigned send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			contact.valid <= 1'b0;
			contact.data  <= '0;
			send_gap <= 0;
		end else if (contact.valid && !contact.ready) begin
			// hold the beat on offer
		end else if (send_gap != 0) begin
			contact.valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (pending_contacts.size() != 0) begin
			contact.valid <= 1'b1;
			contact.data  <= pending_contacts.pop_front();
			send_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4) : 0;
		end else begin
			contact.valid <= 1'b0;
		end
	end

	// prediction on every accepted contact
	always @(posedge clk) begin
		if (arst_n && contact.valid && contact.ready) begin
			expected_results.push_back(resolve_contact(contact.data));
			n_sent++;
			if (resolve_contact(contact.data).separating) n_sep++;
			if (contact.data.inv_mass_a == 0 && contact.data.inv_mass_b == 0) n_zero_mass++;
			if (n_sent == 400) hold_long <= 1'b1;
		end
	end

	// receiver stalls, with one long hold-off partway through
	int unsigned stall_left = 0, long_count = 0;
	always @(posedge clk or negedge arst_n) begin
		int unsigned draw;
		if (!arst_n) begin
			result.ready <= 1'b0;
			stall_left <= 0;
			long_count <= 0;
		end else if (hold_long && long_count < 300) begin
			result.ready <= 1'b0;
			long_count <= long_count + 1;
		end else if (result.valid && result.ready) begin
			draw = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4) : 0;
			result.ready <= (draw == 0);
			stall_left <= draw;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result.ready <= (stall_left == 1);
		end else begin
			result.ready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		cif_out_t exp_r;
		if (arst_n && result.valid && result.ready) begin
			n_got++;
			if (expected_results.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (result.data.new_vel_a_x !== exp_r.new_vel_a_x) begin
					$error("new_vel_a_x exp %0d got %0d", exp_r.new_vel_a_x,
						result.data.new_vel_a_x);
					errors++;
				end
				if (result.data.new_vel_a_y !== exp_r.new_vel_a_y) begin
					$error("new_vel_a_y exp %0d got %0d", exp_r.new_vel_a_y,
						result.data.new_vel_a_y);
					errors++;
				end
				if (result.data.new_vel_b_x !== exp_r.new_vel_b_x) begin
					$error("new_vel_b_x exp %0d got %0d", exp_r.new_vel_b_x,
						result.data.new_vel_b_x);
					errors++;
				end
				if (result.data.new_vel_b_y !== exp_r.new_vel_b_y) begin
					$error("new_vel_b_y exp %0d got %0d", exp_r.new_vel_b_y,
						result.data.new_vel_b_y);
					errors++;
				end
				if (result.data.normal_impulse !== exp_r.normal_impulse) begin
					$error("normal_impulse exp %0d got %0d", exp_r.normal_impulse,
						result.data.normal_impulse);
					errors++;
				end
				if (result.data.separating !== exp_r.separating) begin
					$error("separating exp %0b got %0b", exp_r.separating,
						result.data.separating);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles without any beat on either side
	int unsigned idle_cycles = 0;
	always @(posedge clk) begin
		if ((contact.valid && contact.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("timeout with %0d results outstanding", expected_results.size());
			$display("FAIL");
			$finish;
		end
	end

	// end of run
	initial begin
		wait (arst_n);
		wait (pending_contacts.size() == 0 && !contact.valid);
		wait (expected_results.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		$display("contacts %0d, results %0d, separating %0d, immovable pairs %0d",
			n_sent, n_got, n_sep, n_zero_mass);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
